@@ rtl/jsc_pkg.sv @@
// Shared types, token codes, literal helpers and token-rule function for the JSON syntax checker.
// No dependencies; the files that use it refer to this package by scoped names.
package jsc_pkg;

   typedef enum logic [1:0] {MODE_OUT, MODE_STR, MODE_NUM, MODE_LIT} mode_type;
   typedef enum logic [1:0] {NC_DIGIT, NC_SIGN, NC_POINT, NC_EXP} num_class_type;
   typedef enum logic [1:0] {NN_NONE, NN_DIGIT, NN_DIGIT_OR_SIGN} num_need_type;
   typedef enum logic [1:0] {LIT_TRUE, LIT_FALSE, LIT_NULL} lit_kind_type;
   typedef enum logic [3:0] {
      TK_LBRACE = 4'd1, TK_LBRACKET = 4'd2, TK_RBRACE = 4'd3, TK_RBRACKET = 4'd4,
      TK_COMMA = 4'd5, TK_COLON = 4'd6, TK_STRING = 4'd7, TK_SCALAR = 4'd8
   } token_type;
   typedef enum logic [2:0] {
      PC_NONE, PC_LBRACE, PC_LBRACKET, PC_CLOSE, PC_COMMA, PC_COLON, PC_STRING, PC_SCALAR
   } prev_class_type;
   typedef enum logic [2:0] {
      TN_NONE, TN_KEY_OR_RBRACE, TN_VAL_OR_RBRACKET, TN_KEY, TN_VAL
   } tok_need_type;

   // everything but the bracket stack and its depth
   typedef struct packed {
      mode_type       mode;
      logic           escape_odd;
      logic [1:0]     exponent_count;
      logic [1:0]     sign_count;
      logic [1:0]     point_count;
      num_class_type  num_prev;
      num_need_type   num_need;
      lit_kind_type   lit_kind;
      logic [2:0]     lit_pos;
      prev_class_type prev_tok;
      tok_need_type   next_need;
      logic [1:0]     root_count;
      logic           seen_token;
      logic           failed;
      logic           overflowed;
   } chk_state_type;

   typedef struct packed {
      chk_state_type st;
      logic          push;
      logic          push_obj;
      logic          pop;
   } emit_res_type;

   localparam chk_state_type CHK_STATE_RESET = '{
      mode: MODE_OUT, escape_odd: 1'b0, exponent_count: 2'd0, sign_count: 2'd0,
      point_count: 2'd0, num_prev: NC_DIGIT, num_need: NN_NONE, lit_kind: LIT_TRUE,
      lit_pos: 3'd0, prev_tok: PC_NONE, next_need: TN_NONE, root_count: 2'd0,
      seen_token: 1'b0, failed: 1'b0, overflowed: 1'b0};

   function automatic logic [7:0] lit_char(lit_kind_type kind, logic [2:0] pos);
      logic [7:0] ch;
      ch = 8'h00;
      case (kind)
         LIT_TRUE: begin
            case (pos)
               3'd0: ch = "t";
               3'd1: ch = "r";
               3'd2: ch = "u";
               3'd3: ch = "e";
               default: ch = 8'h00;
            endcase
         end
         LIT_FALSE: begin
            case (pos)
               3'd0: ch = "f";
               3'd1: ch = "a";
               3'd2: ch = "l";
               3'd3: ch = "s";
               3'd4: ch = "e";
               default: ch = 8'h00;
            endcase
         end
         LIT_NULL: begin
            case (pos)
               3'd0: ch = "n";
               3'd1: ch = "u";
               3'd2: ch = "l";
               3'd3: ch = "l";
               default: ch = 8'h00;
            endcase
         end
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   function automatic logic [2:0] lit_len(lit_kind_type kind);
      return (kind == LIT_FALSE) ? 3'd5 : 3'd4;
   endfunction

   // Structure rules for one token; stack effect returned as push/pop request.
   function automatic emit_res_type emit_token(chk_state_type s, token_type tk,
                                               logic depth_zero, logic depth_full,
                                               logic top_obj);
      emit_res_type r;
      logic         is_val;
      logic         ok;
      logic         obj;
      r          = '{st: s, push: 1'b0, push_obj: 1'b0, pop: 1'b0};
      obj        = !depth_zero && top_obj;
      is_val     = (tk == TK_LBRACE) || (tk == TK_LBRACKET) ||
                   (tk == TK_STRING) || (tk == TK_SCALAR);
      ok         = 1'b1;
      case (s.next_need)
         TN_KEY_OR_RBRACE:   ok = (tk == TK_STRING) || (tk == TK_RBRACE);
         TN_VAL_OR_RBRACKET: ok = is_val || (tk == TK_RBRACKET);
         TN_KEY:             ok = (tk == TK_STRING);
         TN_VAL:             ok = is_val;
         default:            ok = 1'b1;
      endcase
      r.st.seen_token = 1'b1;
      if (!ok) r.st.failed = 1'b1;
      r.st.next_need = TN_NONE;
      case (tk)
         TK_LBRACE, TK_LBRACKET: begin
            if (depth_zero) begin
               if (s.root_count != 2'd2) r.st.root_count = s.root_count + 2'd1;
               if (s.root_count != 2'd0) r.st.failed = 1'b1;
            end
            r.st.next_need = (tk == TK_LBRACE) ? TN_KEY_OR_RBRACE : TN_VAL_OR_RBRACKET;
            if (!depth_full) begin
               r.push     = 1'b1;
               r.push_obj = (tk == TK_LBRACE);
            end else begin
               r.st.overflowed = 1'b1;
               r.st.failed     = 1'b1;
            end
            r.st.prev_tok = (tk == TK_LBRACE) ? PC_LBRACE : PC_LBRACKET;
         end
         TK_RBRACE, TK_RBRACKET: begin
            if (depth_zero || (obj != (tk == TK_RBRACE))) r.st.failed = 1'b1;
            else r.pop = 1'b1;
            r.st.prev_tok = PC_CLOSE;
         end
         TK_COLON: begin
            if (!obj || s.prev_tok != PC_STRING) r.st.failed = 1'b1;
            r.st.next_need = TN_VAL;
            r.st.prev_tok  = PC_COLON;
         end
         TK_COMMA: begin
            if (depth_zero) r.st.failed = 1'b1;
            if (!(s.prev_tok == PC_CLOSE || s.prev_tok == PC_STRING ||
                  s.prev_tok == PC_SCALAR)) r.st.failed = 1'b1;
            r.st.next_need = obj ? TN_KEY : TN_VAL;
            r.st.prev_tok  = PC_COMMA;
         end
         default: begin
            if (depth_zero) begin
               if (s.root_count != 2'd2) r.st.root_count = s.root_count + 2'd1;
               if (s.root_count != 2'd0) r.st.failed = 1'b1;
            end
            r.st.prev_tok = (tk == TK_STRING) ? PC_STRING : PC_SCALAR;
         end
      endcase
      return r;
   endfunction

endpackage

@@ rtl/jsc_req_if.sv @@
// Request channel: one document byte per transfer, valid/ready handshake.
// No dependencies.
interface jsc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_doc;
   modport source (output valid, output data_byte, output end_of_doc, input ready);
   modport sink (input valid, input data_byte, input end_of_doc, output ready);
endinterface

@@ rtl/jsc_rsp_if.sv @@
// Response channel: one verdict per document, valid/ready handshake.
// No dependencies.
interface jsc_rsp_if;
   logic valid;
   logic ready;
   logic doc_valid;
   logic depth_overflow;
   modport source (output valid, output doc_valid, output depth_overflow, input ready);
   modport sink (input valid, input doc_valid, input depth_overflow, output ready);
endinterface

@@ rtl/json_syntax_checker_top.sv @@
// Top level of the JSON syntax checker: input stage, core and response register.
// Depends on jsc_pkg, jsc_req_if, jsc_rsp_if, jsc_ram and jsc_core.

// Takes a JSON document one byte per request and returns one response on the
// byte flagged end_of_doc: doc_valid is 1 when the document is well formed,
// depth_overflow is 1 when nesting went deeper than STACK_DEPTH (that document
// is then invalid). A byte is accepted every cycle unless stalled as below; each
// byte passes through the input register, and the verdict of a document's last
// byte is captured in the response register. Bytes keep flowing while a response
// waits; only a second end-of-document byte stalls until the waiting response is
// taken. The bracket stack is a one-bit RAM of STACK_DEPTH entries with the top
// level kept in a register, so open and close need no wait for a RAM read.
// No initialization pass is needed after reset.
module json_syntax_checker_top #(
   parameter int STACK_DEPTH = 64
) (
   input  logic  clock,
   input  logic  reset,
   jsc_req_if.sink   req_chan,
   jsc_rsp_if.source rsp_chan
);
   logic       stg_valid_ff, stg_valid_in;
   logic [7:0] stg_byte_ff;
   logic       stg_eod_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_doc_ff, rsp_ovf_ff;
   logic       advance, core_doc, core_ovf;

   assign advance        = stg_valid_ff && (!stg_eod_ff || !rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !stg_valid_ff || advance;
   assign stg_valid_in   = req_chan.valid || (stg_valid_ff && !advance);
   assign rsp_valid_in   = (advance && stg_eod_ff) || (rsp_valid_ff && !rsp_chan.ready);

   jsc_core #(.STACK_DEPTH(STACK_DEPTH)) u_core (
      .clock          (clock),
      .reset          (reset),
      .step           (advance),
      .data_byte      (stg_byte_ff),
      .end_of_doc     (stg_eod_ff),
      .doc_valid      (core_doc),
      .depth_overflow (core_ovf)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         stg_valid_ff <= stg_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_chan.ready) begin
         stg_byte_ff <= req_chan.data_byte;
         stg_eod_ff  <= req_chan.end_of_doc;
      end
      if (advance && stg_eod_ff) begin
         rsp_doc_ff <= core_doc;
         rsp_ovf_ff <= core_ovf;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.doc_valid      = rsp_doc_ff;
   assign rsp_chan.depth_overflow = rsp_ovf_ff;
endmodule

@@ rtl/jsc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module jsc_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 64
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

@@ rtl/jsc_core.sv @@
// Lexer, structure rules and bracket stack; one byte processed per step.
// Depends on jsc_pkg and jsc_ram.
module jsc_core #(
   parameter int STACK_DEPTH = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] data_byte,
   input  logic       end_of_doc,
   output logic       doc_valid,
   output logic       depth_overflow
);
   localparam int DW = $clog2(STACK_DEPTH + 1);
   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam logic [DW-1:0] DEPTH_MAX = DW'(STACK_DEPTH);

   jsc_pkg::chk_state_type st_ff, st_in, s;
   jsc_pkg::emit_res_type  r1, r2;
   logic [DW-1:0] depth_ff, depth_in, depth_after;
   logic          top_ff, top_in;
   logic          fwd_valid_ff, fwd_valid_in, fwd_data_ff;
   logic          below, rd_data;
   logic          depth_zero, depth_full;
   logic          do_scalar, do_tok, delim, push, pop, push_obj;
   jsc_pkg::token_type tk;
   logic [2:0]    next_pos;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [DW-1:0] rd_depth;

   assign depth_zero = (depth_ff == '0);
   assign depth_full = (depth_ff == DEPTH_MAX);
   assign below      = fwd_valid_ff ? fwd_data_ff : rd_data;

   always_comb begin
      s         = st_ff;
      do_scalar = 1'b0;
      do_tok    = 1'b0;
      tk        = jsc_pkg::TK_SCALAR;
      next_pos  = st_ff.lit_pos + 3'd1;
      delim     = data_byte inside {"}", "]", ",", " ", 8'h0A, 8'h0D, 8'h09};
      r1        = '{st: s, push: 1'b0, push_obj: 1'b0, pop: 1'b0};
      r2        = r1;
      case (st_ff.mode)
         jsc_pkg::MODE_STR: begin
            if (data_byte == "\"" && !st_ff.escape_odd) begin
               s.mode = jsc_pkg::MODE_OUT;
               do_tok = 1'b1;
               tk     = jsc_pkg::TK_STRING;
            end else begin
               s.escape_odd = (data_byte == "\\") ? !st_ff.escape_odd : 1'b0;
            end
         end
         jsc_pkg::MODE_LIT: begin
            if (st_ff.lit_pos >= jsc_pkg::lit_len(st_ff.lit_kind) ||
                jsc_pkg::lit_char(st_ff.lit_kind, st_ff.lit_pos) != data_byte) begin
               s.failed = 1'b1;
               s.mode   = jsc_pkg::MODE_OUT;
            end else begin
               s.lit_pos = next_pos;
               if (next_pos == jsc_pkg::lit_len(st_ff.lit_kind)) begin
                  s.mode = jsc_pkg::MODE_OUT;
                  do_tok = 1'b1;
               end
            end
         end
         jsc_pkg::MODE_NUM: begin
            if (delim) begin
               // number ends here; the delimiter is then handled as usual below
               if (st_ff.num_need != jsc_pkg::NN_NONE || st_ff.num_prev != jsc_pkg::NC_DIGIT)
                  s.failed = 1'b1;
               s.mode    = jsc_pkg::MODE_OUT;
               do_scalar = 1'b1;
            end else begin
               if (st_ff.num_need == jsc_pkg::NN_DIGIT && !(data_byte inside {["0":"9"]}))
                  s.failed = 1'b1;
               if (st_ff.num_need == jsc_pkg::NN_DIGIT_OR_SIGN &&
                   !(data_byte inside {["0":"9"], "+", "-"}))
                  s.failed = 1'b1;
               if (data_byte inside {["0":"9"]}) begin
                  s.num_prev = jsc_pkg::NC_DIGIT;
                  s.num_need = jsc_pkg::NN_NONE;
               end else if (data_byte inside {"e", "E"}) begin
                  if (st_ff.exponent_count != 2'd3) s.exponent_count = st_ff.exponent_count + 2'd1;
                  if (st_ff.exponent_count != 2'd0 || st_ff.num_prev != jsc_pkg::NC_DIGIT)
                     s.failed = 1'b1;
                  s.num_prev = jsc_pkg::NC_EXP;
                  s.num_need = jsc_pkg::NN_DIGIT_OR_SIGN;
               end else if (data_byte == ".") begin
                  if (st_ff.point_count != 2'd3) s.point_count = st_ff.point_count + 2'd1;
                  if (st_ff.point_count != 2'd0 || st_ff.num_prev != jsc_pkg::NC_DIGIT)
                     s.failed = 1'b1;
                  s.num_prev = jsc_pkg::NC_POINT;
                  s.num_need = jsc_pkg::NN_DIGIT;
               end else if (data_byte inside {"+", "-"}) begin
                  if (st_ff.sign_count != 2'd3) s.sign_count = st_ff.sign_count + 2'd1;
                  if (st_ff.sign_count >= 2'd2 || st_ff.num_prev != jsc_pkg::NC_EXP)
                     s.failed = 1'b1;
                  s.num_prev = jsc_pkg::NC_SIGN;
                  s.num_need = jsc_pkg::NN_DIGIT;
               end else begin
                  s.failed = 1'b1;
                  s.mode   = jsc_pkg::MODE_OUT;
               end
            end
         end
         default: begin
         end
      endcase

      if (st_ff.mode == jsc_pkg::MODE_OUT || do_scalar) begin
         case (data_byte)
            "{": begin do_tok = 1'b1; tk = jsc_pkg::TK_LBRACE; end
            "[": begin do_tok = 1'b1; tk = jsc_pkg::TK_LBRACKET; end
            "}": begin do_tok = 1'b1; tk = jsc_pkg::TK_RBRACE; end
            "]": begin do_tok = 1'b1; tk = jsc_pkg::TK_RBRACKET; end
            ",": begin do_tok = 1'b1; tk = jsc_pkg::TK_COMMA; end
            ":": begin do_tok = 1'b1; tk = jsc_pkg::TK_COLON; end
            "\"": begin
               s.mode       = jsc_pkg::MODE_STR;
               s.escape_odd = 1'b0;
            end
            "t", "f", "n": begin
               s.mode     = jsc_pkg::MODE_LIT;
               s.lit_kind = (data_byte == "t") ? jsc_pkg::LIT_TRUE :
                            (data_byte == "f") ? jsc_pkg::LIT_FALSE : jsc_pkg::LIT_NULL;
               s.lit_pos  = 3'd1;
            end
            default: begin
               if (data_byte inside {["0":"9"], "+", "-"}) begin
                  s.mode           = jsc_pkg::MODE_NUM;
                  s.exponent_count = 2'd0;
                  s.point_count    = 2'd0;
                  s.sign_count     = (data_byte inside {"+", "-"}) ? 2'd1 : 2'd0;
                  s.num_prev       = (data_byte inside {"+", "-"}) ?
                                     jsc_pkg::NC_SIGN : jsc_pkg::NC_DIGIT;
                  s.num_need       = (data_byte inside {"+", "-"}) ?
                                     jsc_pkg::NN_DIGIT : jsc_pkg::NN_NONE;
               end
            end
         endcase
      end

      // end of document inside a number closes it as a scalar
      if (end_of_doc && s.mode == jsc_pkg::MODE_NUM) begin
         if (s.num_need != jsc_pkg::NN_NONE || s.num_prev != jsc_pkg::NC_DIGIT)
            s.failed = 1'b1;
         s.mode    = jsc_pkg::MODE_OUT;
         do_scalar = 1'b1;
      end

      r1 = do_scalar ? jsc_pkg::emit_token(s, jsc_pkg::TK_SCALAR, depth_zero, depth_full, top_ff)
                     : '{st: s, push: 1'b0, push_obj: 1'b0, pop: 1'b0};
      r2 = do_tok ? jsc_pkg::emit_token(r1.st, tk, depth_zero, depth_full, top_ff) : r1;
   end

   assign push     = do_tok && r2.push;
   assign pop      = do_tok && r2.pop;
   assign push_obj = r2.push_obj;

   always_comb begin
      depth_after = depth_ff;
      if (push) depth_after = depth_ff + DW'(1);
      else if (pop) depth_after = depth_ff - DW'(1);
      doc_valid      = !r2.st.failed;
      depth_overflow = r2.st.overflowed;
      if (r2.st.mode == jsc_pkg::MODE_STR || r2.st.mode == jsc_pkg::MODE_LIT ||
          r2.st.next_need != jsc_pkg::TN_NONE || depth_after != '0 ||
          r2.st.root_count > 2'd1 || !r2.st.seen_token)
         doc_valid = 1'b0;

      st_in    = st_ff;
      depth_in = depth_ff;
      top_in   = top_ff;
      if (step) begin
         st_in    = end_of_doc ? jsc_pkg::CHK_STATE_RESET : r2.st;
         depth_in = end_of_doc ? '0 : depth_after;
         if (push) top_in = push_obj;
         else if (pop) top_in = below;
      end
   end

   // stack RAM holds every level below the top; the top lives in top_ff
   assign wr_addr      = AW'(depth_ff - DW'(1));
   assign rd_depth     = depth_in - DW'(2);
   assign rd_addr      = AW'(rd_depth);
   assign fwd_valid_in = step && push && !depth_zero && (wr_addr == rd_addr);

   jsc_ram #(.WIDTH(1), .DEPTH(STACK_DEPTH)) u_stack (
      .clock   (clock),
      .wr_en   (step && push && !depth_zero),
      .wr_addr (wr_addr),
      .wr_data (top_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= jsc_pkg::CHK_STATE_RESET;
         depth_ff     <= '0;
         fwd_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         depth_ff     <= depth_in;
         fwd_valid_ff <= fwd_valid_in;
      end
      top_ff      <= top_in;
      fwd_data_ff <= top_ff;
   end

`ifndef SYNTHESIS
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DEPTH_MAX) else $error("stack depth beyond limit");
   a_push_pop_excl: assert property (@(posedge clock) disable iff (reset)
      !(push && pop)) else $error("push and pop in one step");
   a_doc_clears: assert property (@(posedge clock) disable iff (reset)
      step && end_of_doc |=> depth_ff == '0 && st_ff.mode == jsc_pkg::MODE_OUT &&
      !st_ff.failed) else $error("state not cleared after document");
   a_full_no_push: assert property (@(posedge clock) disable iff (reset)
      step && depth_full |-> !push) else $error("push on full stack");
`endif
endmodule

@@ bench/tb_top.sv @@
// Bench for json_syntax_checker_top: streams JSON documents byte by byte and checks
// each verdict against a behavioral predictor. Depends on jsc_pkg, jsc_req_if,
// jsc_rsp_if and the RTL top level.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH_MAX = 64;
   localparam int WDOG_LIMIT = 3000;
   localparam int HOLD_CYCLES = 300;

   typedef struct {
      logic [7:0] data;
      logic       eod;
      int         phase;
   } req_item_type;

   typedef struct {
      logic ok;
      logic ovf;
   } verdict_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   jsc_req_if req_chan ();
   jsc_rsp_if rsp_chan ();

   json_syntax_checker_top #(.STACK_DEPTH(DEPTH_MAX)) u_top (
      .clock(clock), .reset(reset), .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source));

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   req_item_type byte_queue[$];
   verdict_type  verdicts_due[$];
   int           cur_phase = 0;
   int           errors = 0;
   int           idle_cycles = 0;

   // ---------------- predictor state ----------------
   logic                    stk[DEPTH_MAX];
   int                      depth;
   jsc_pkg::mode_type       mode;
   bit                      esc_odd;
   int                      exp_cnt, sgn_cnt, pt_cnt;
   jsc_pkg::num_class_type  nprev;
   jsc_pkg::num_need_type   nneed;
   jsc_pkg::lit_kind_type   lkind;
   int                      lpos;
   jsc_pkg::prev_class_type ptok;
   jsc_pkg::tok_need_type   tneed;
   int                      roots;
   bit                      seen, bad, ovf;
   string                   lit_word[3] = '{"true", "false", "null"};

   function automatic void clear_doc();
      mode = jsc_pkg::MODE_OUT; esc_odd = 0; exp_cnt = 0; sgn_cnt = 0; pt_cnt = 0;
      nprev = jsc_pkg::NC_DIGIT; nneed = jsc_pkg::NN_NONE; lkind = jsc_pkg::LIT_TRUE;
      lpos = 0; ptok = jsc_pkg::PC_NONE; tneed = jsc_pkg::TN_NONE; depth = 0; roots = 0;
      seen = 0; bad = 0; ovf = 0;
   endfunction

   function automatic bit top_obj();
      return depth > 0 && stk[depth-1];
   endfunction

   function automatic void bump_root();
      if (depth == 0) begin
         if (roots < 2) roots++;
         if (roots >= 2) bad = 1;
      end
   endfunction

   function automatic void take_token(jsc_pkg::token_type tk);
      bit is_val;
      bit ok;
      is_val = tk inside {jsc_pkg::TK_LBRACE, jsc_pkg::TK_LBRACKET, jsc_pkg::TK_STRING,
                          jsc_pkg::TK_SCALAR};
      ok = 1;
      seen = 1;
      case (tneed)
         jsc_pkg::TN_KEY_OR_RBRACE:
            ok = (tk == jsc_pkg::TK_STRING || tk == jsc_pkg::TK_RBRACE);
         jsc_pkg::TN_VAL_OR_RBRACKET: ok = is_val || tk == jsc_pkg::TK_RBRACKET;
         jsc_pkg::TN_KEY:             ok = (tk == jsc_pkg::TK_STRING);
         jsc_pkg::TN_VAL:             ok = is_val;
         default:                     ok = 1;
      endcase
      if (!ok) bad = 1;
      tneed = jsc_pkg::TN_NONE;
      case (tk)
         jsc_pkg::TK_LBRACE, jsc_pkg::TK_LBRACKET: begin
            bump_root();
            tneed = (tk == jsc_pkg::TK_LBRACE) ? jsc_pkg::TN_KEY_OR_RBRACE :
                                                 jsc_pkg::TN_VAL_OR_RBRACKET;
            if (depth < DEPTH_MAX) begin
               stk[depth] = (tk == jsc_pkg::TK_LBRACE);
               depth++;
            end else begin
               ovf = 1;
               bad = 1;
            end
            ptok = (tk == jsc_pkg::TK_LBRACE) ? jsc_pkg::PC_LBRACE : jsc_pkg::PC_LBRACKET;
         end
         jsc_pkg::TK_RBRACE, jsc_pkg::TK_RBRACKET: begin
            if (depth == 0 || top_obj() != (tk == jsc_pkg::TK_RBRACE)) bad = 1;
            else depth--;
            ptok = jsc_pkg::PC_CLOSE;
         end
         jsc_pkg::TK_COLON: begin
            if (!top_obj() || ptok != jsc_pkg::PC_STRING) bad = 1;
            tneed = jsc_pkg::TN_VAL;
            ptok = jsc_pkg::PC_COLON;
         end
         jsc_pkg::TK_COMMA: begin
            if (depth == 0) bad = 1;
            if (!(ptok inside {jsc_pkg::PC_CLOSE, jsc_pkg::PC_STRING, jsc_pkg::PC_SCALAR}))
               bad = 1;
            tneed = top_obj() ? jsc_pkg::TN_KEY : jsc_pkg::TN_VAL;
            ptok = jsc_pkg::PC_COMMA;
         end
         default: begin
            bump_root();
            ptok = (tk == jsc_pkg::TK_STRING) ? jsc_pkg::PC_STRING : jsc_pkg::PC_SCALAR;
         end
      endcase
   endfunction

   function automatic void close_number();
      if (nneed != jsc_pkg::NN_NONE || nprev != jsc_pkg::NC_DIGIT) bad = 1;
      mode = jsc_pkg::MODE_OUT;
      take_token(jsc_pkg::TK_SCALAR);
   endfunction

   function automatic bit is_dig(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit is_sgn(logic [7:0] c);
      return c == "+" || c == "-";
   endfunction

   function automatic void number_char(logic [7:0] c);
      if (nneed == jsc_pkg::NN_DIGIT && !is_dig(c)) bad = 1;
      if (nneed == jsc_pkg::NN_DIGIT_OR_SIGN && !(is_dig(c) || is_sgn(c))) bad = 1;
      if (is_dig(c)) begin
         nprev = jsc_pkg::NC_DIGIT; nneed = jsc_pkg::NN_NONE;
      end else if (c == "e" || c == "E") begin
         if (exp_cnt < 3) exp_cnt++;
         if (exp_cnt > 1 || nprev != jsc_pkg::NC_DIGIT) bad = 1;
         nprev = jsc_pkg::NC_EXP; nneed = jsc_pkg::NN_DIGIT_OR_SIGN;
      end else if (c == ".") begin
         if (pt_cnt < 3) pt_cnt++;
         if (pt_cnt > 1 || nprev != jsc_pkg::NC_DIGIT) bad = 1;
         nprev = jsc_pkg::NC_POINT; nneed = jsc_pkg::NN_DIGIT;
      end else if (is_sgn(c)) begin
         if (sgn_cnt < 3) sgn_cnt++;
         if (sgn_cnt > 2 || nprev != jsc_pkg::NC_EXP) bad = 1;
         nprev = jsc_pkg::NC_SIGN; nneed = jsc_pkg::NN_DIGIT;
      end else begin
         bad = 1;
         mode = jsc_pkg::MODE_OUT;
      end
   endfunction

   function automatic void free_char(logic [7:0] c);
      case (c)
         "{": take_token(jsc_pkg::TK_LBRACE);
         "[": take_token(jsc_pkg::TK_LBRACKET);
         "}": take_token(jsc_pkg::TK_RBRACE);
         "]": take_token(jsc_pkg::TK_RBRACKET);
         ",": take_token(jsc_pkg::TK_COMMA);
         ":": take_token(jsc_pkg::TK_COLON);
         "\"": begin
            mode = jsc_pkg::MODE_STR; esc_odd = 0;
         end
         "t", "f", "n": begin
            mode = jsc_pkg::MODE_LIT;
            lkind = (c == "t") ? jsc_pkg::LIT_TRUE :
                    (c == "f") ? jsc_pkg::LIT_FALSE : jsc_pkg::LIT_NULL;
            lpos = 1;
         end
         default: begin
            if (is_dig(c) || is_sgn(c)) begin
               mode = jsc_pkg::MODE_NUM; exp_cnt = 0; pt_cnt = 0;
               sgn_cnt = is_sgn(c) ? 1 : 0;
               nprev = is_sgn(c) ? jsc_pkg::NC_SIGN : jsc_pkg::NC_DIGIT;
               nneed = is_sgn(c) ? jsc_pkg::NN_DIGIT : jsc_pkg::NN_NONE;
            end
         end
      endcase
   endfunction

   function automatic void scan_char(logic [7:0] c);
      string w;
      w = lit_word[int'(lkind)];
      if (mode == jsc_pkg::MODE_STR) begin
         if (c == "\"" && !esc_odd) begin
            mode = jsc_pkg::MODE_OUT;
            take_token(jsc_pkg::TK_STRING);
         end else
            esc_odd = (c == "\\") ? !esc_odd : 1'b0;
         return;
      end
      if (mode == jsc_pkg::MODE_LIT) begin
         if (lpos >= w.len() || w[lpos] != c) begin
            bad = 1;
            mode = jsc_pkg::MODE_OUT;
            return;
         end
         lpos++;
         if (lpos == w.len()) begin
            mode = jsc_pkg::MODE_OUT;
            take_token(jsc_pkg::TK_SCALAR);
         end
         return;
      end
      if (mode == jsc_pkg::MODE_NUM) begin
         if (c inside {"}", "]", ",", " ", 8'h0a, 8'h0d, 8'h09}) close_number();
         else begin
            number_char(c);
            return;
         end
      end
      free_char(c);
   endfunction

   // Feeds one accepted request; queues the verdict on the last byte.
   function automatic void judge_byte(logic [7:0] c, logic eod);
      verdict_type v;
      scan_char(c);
      if (!eod) return;
      if (mode == jsc_pkg::MODE_STR || mode == jsc_pkg::MODE_LIT) bad = 1;
      else if (mode == jsc_pkg::MODE_NUM) close_number();
      if (tneed != jsc_pkg::TN_NONE || depth != 0 || roots > 1 || !seen) bad = 1;
      v.ok = !bad;
      v.ovf = ovf;
      verdicts_due = {verdicts_due, v};
      clear_doc();
   endfunction

   // ---------------- driver ----------------
   function automatic int sender_idle_pct(int ph);
      return (ph == 1) ? 69 : (ph == 3) ? 35 : 0;
   endfunction

   function automatic int recv_stall_pct(int ph);
      return (ph == 2) ? 69 : (ph == 3) ? 35 : 0;
   endfunction

   initial begin
      req_chan.valid = 1'b0;
      req_chan.data_byte = 8'h00;
      req_chan.end_of_doc = 1'b0;
      rsp_chan.ready = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            judge_byte(req_chan.data_byte, req_chan.end_of_doc);
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (byte_queue.size() > 0 &&
                $urandom_range(99, 0) >= sender_idle_pct(byte_queue[0].phase)) begin
               req_item_type it;
               it = byte_queue.pop_front();
               cur_phase <= it.phase;
               req_chan.valid <= 1'b1;
               req_chan.data_byte <= it.data;
               req_chan.end_of_doc <= it.eod;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------- monitor ----------------
   int hold_left = HOLD_CYCLES;

   // long hold-off once the back-pressure phase starts
   always @(posedge clock) begin
      if (!reset && cur_phase == 4 && hold_left > 0)
         hold_left <= hold_left - 1;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (verdicts_due.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("unexpected verdict: doc_valid=%0b depth_overflow=%0b",
                           rsp_chan.doc_valid, rsp_chan.depth_overflow);
            end else begin
               verdict_type v;
               v = verdicts_due.pop_front();
               if (v.ok !== rsp_chan.doc_valid || v.ovf !== rsp_chan.depth_overflow) begin
                  errors++;
                  if (errors <= 10)
                     $display("verdict mismatch: expected valid=%0b ovf=%0b, got valid=%0b ovf=%0b",
                              v.ok, v.ovf, rsp_chan.doc_valid, rsp_chan.depth_overflow);
               end
            end
         end
         if (cur_phase == 4 && hold_left > 0)
            rsp_chan.ready <= 1'b0;
         else
            rsp_chan.ready <= ($urandom_range(99, 0) >= recv_stall_pct(cur_phase));
      end
   end

   // ---------------- watchdog ----------------
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
             (cur_phase == 4 && hold_left > 0))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   // ---------------- stimulus ----------------
   function automatic void add_text(string s, int ph);
      req_item_type it;
      for (int i = 0; i < s.len(); i++) begin
         it.data = s[i];
         it.eod = (i == s.len() - 1);
         it.phase = ph;
         byte_queue = {byte_queue, it};
      end
   endfunction

   function automatic string pad();
      string ws[5] = '{"", "", " ", "\n", "\t"};
      return ws[$urandom_range(4, 0)];
   endfunction

   function automatic string rand_number();
      string s;
      s = "";
      if ($urandom_range(3, 0) == 0) s = "-";
      s = {s, string'(8'("0" + $urandom_range(9, 0)))};
      if ($urandom_range(2, 0) == 0) s = {s, $sformatf("%0d", $urandom_range(999, 0))};
      if ($urandom_range(2, 0) == 0) s = {s, ".", $sformatf("%0d", $urandom_range(99, 0))};
      if ($urandom_range(3, 0) == 0) begin
         if ($urandom_range(1, 0)) s = {s, "e"};
         else s = {s, "E"};
         if ($urandom_range(1, 0)) s = {s, "+"};
         else if ($urandom_range(1, 0)) s = {s, "-"};
         s = {s, $sformatf("%0d", $urandom_range(20, 0))};
      end
      return s;
   endfunction

   function automatic string rand_string();
      string s;
      string pieces[6] = '{"a", "Z9", "\\\"", "\\\\", " :,{}", "\\n"};
      s = "\"";
      repeat ($urandom_range(3, 0)) s = {s, pieces[$urandom_range(5, 0)]};
      return {s, "\""};
   endfunction

   function automatic string rand_value(int lvl);
      string s;
      int n;
      int pick;
      pick = (lvl >= 2) ? $urandom_range(5, 2) : $urandom_range(5, 0);
      case (pick)
         0: begin
            s = "{";
            n = $urandom_range(3, 0);
            for (int i = 0; i < n; i++) begin
               if (i > 0) s = {s, ","};
               s = {s, pad(), rand_string(), pad(), ":", pad(), rand_value(lvl + 1)};
            end
            s = {s, pad(), "}"};
         end
         1: begin
            s = "[";
            n = $urandom_range(3, 0);
            for (int i = 0; i < n; i++) begin
               if (i > 0) s = {s, ","};
               s = {s, pad(), rand_value(lvl + 1)};
            end
            s = {s, pad(), "]"};
         end
         2: s = rand_string();
         3: s = rand_number();
         4: begin
            if ($urandom_range(1, 0)) s = "true";
            else s = "false";
         end
         default: s = "null";
      endcase
      return s;
   endfunction

   function automatic string rand_doc();
      string s;
      int r;
      r = $urandom_range(99, 0);
      if (r < 10) begin
         // pure noise, any nonzero byte values
         s = "";
         repeat ($urandom_range(10, 1)) s = {s, string'(8'($urandom_range(255, 1)))};
         return s;
      end
      s = {pad(), rand_value(0), pad()};
      if (r < 35) begin
         int p;
         p = $urandom_range(s.len() - 1, 0);
         s[p] = 8'($urandom_range(255, 0));
      end else if (r < 42) begin
         s = s.substr(0, $urandom_range(s.len() - 1, 0));
      end
      if (s.len() == 0) s = " ";
      return s;
   endfunction

   initial begin
      string deep_open, deep_close;
      string directed[$];
      directed = '{
         "{\"a\":1,\"b\":[true,false,null]}", "[]", "{}", "-12.5e+3", "0", "1e5", "2E-7",
         "\"ab\\\"c\"", "\"x\\\\\"", "\"abc", "\"", "trux", "fals", "1.", ".5", "1e",
         "1e+", "+1", "1-2", "1.2.3", "1e2e3", "1x", "[1,]", "{\"a\"}", "[1 2]", "1 2",
         "]", "[}", "{\"a\":}", ",", ":", " ", "@#[1]", "{1:2}", "[\"a\":1]", "nullx",
         "[01,-0.0E-00]"};
      clear_doc();
      for (int i = 0; i < DEPTH_MAX; i++) stk[i] = 0;
      foreach (directed[i]) add_text(directed[i], 0);
      // fills the stack exactly, then one more open overflows it
      deep_open = ""; deep_close = "";
      for (int i = 0; i < DEPTH_MAX; i++) begin
         if (i % 16 == 1) begin
            deep_open = {deep_open, "{\"k\":"};
            deep_close = {"}", deep_close};
         end else begin
            deep_open = {deep_open, "["};
            deep_close = {"]", deep_close};
         end
      end
      add_text({deep_open, "[2]", deep_close}, 0);
      add_text({string'(8'hff), string'(8'h80), "[7]", string'(8'h00)}, 0);
      // random part spread over phases 0 to 3 with varying idling and stalls, then back-pressure
      for (int ph = 0; ph < 4; ph++) begin
         int nbytes;
         nbytes = 0;
         while (nbytes < 25) begin
            string d;
            d = rand_doc();
            add_text(d, ph);
            nbytes += d.len();
         end
      end
      repeat (12) begin
         if ($urandom_range(1, 0)) add_text("1 ", 4);
         else add_text("[x]", 4);
      end
      add_text("{\"tail\":[1,2]}", 0);

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      wait (byte_queue.size() == 0 && verdicts_due.size() == 0 && !req_chan.valid);
      repeat (10) @(posedge clock);
      if (errors == 0 && verdicts_due.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
